[rtl/qrs_pkg.sv]
// Shared constants and types for the quadratic root solver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int ROOT_WIDTH     = 34;
   localparam int FRAC_BITS      = 16;
   localparam int STATUS_WIDTH   = 2;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_REAL     = 2'd0,
      STATUS_IMAG     = 2'd1,
      STATUS_NOT_QUAD = 2'd2
   } status_type;

endpackage

`default_nettype wire

[rtl/qrs_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Depends on qrs_pkg; the radicand is the discriminant scaled by 2^32.
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int TAG_W      = 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [2*COEF_WIDTH+33:0]  in_rad,
   input  wire logic [TAG_W-1:0]          in_tag,
   output logic                           out_valid,
   output logic [COEF_WIDTH+16:0]         out_root,
   output logic [TAG_W-1:0]               out_tag
);

   localparam int SW = 2*COEF_WIDTH + 34;
   localparam int QW = COEF_WIDTH + 17;
   localparam int RW = QW + 2;

   logic             v_ff   [QW+1];
   logic [SW-1:0]    rad_ff [QW+1];
   logic [RW-1:0]    rem_ff [QW+1];
   logic [QW-1:0]    root_ff[QW+1];
   logic [TAG_W-1:0] tag_ff [QW+1];

   // Index 0 is the unregistered entry point of the chain.
   always_comb begin
      v_ff[0]    = in_valid;
      rad_ff[0]  = in_rad;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      tag_ff[0]  = in_tag;
   end

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [RW+1:0] rs_in;
      logic [RW+1:0] trial_in;
      logic          ge_in;

      always_comb begin
         rs_in    = {rem_ff[i], rad_ff[i][SW-1:SW-2]};
         trial_in = {2'b00, root_ff[i], 2'b01};
         ge_in    = (rs_in >= trial_in);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            rad_ff[i+1]  <= {rad_ff[i][SW-3:0], 2'b00};
            rem_ff[i+1]  <= ge_in ? RW'(rs_in - trial_in) : RW'(rs_in);
            root_ff[i+1] <= {root_ff[i][QW-2:0], ge_in};
            tag_ff[i+1]  <= tag_ff[i];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_root  = root_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

`default_nettype wire

[rtl/qrs_div.sv]
// Pipelined restoring divider for two numerators over one divisor, one
// quotient bit per register stage. Depends on qrs_pkg; magnitudes only.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int TAG_W      = 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [COEF_WIDTH+18:0]    in_num_p,
   input  wire logic [COEF_WIDTH+18:0]    in_num_m,
   input  wire logic [COEF_WIDTH:0]       in_den,
   input  wire logic [TAG_W-1:0]          in_tag,
   output logic                           out_valid,
   output logic [COEF_WIDTH+18:0]         out_quo_p,
   output logic [COEF_WIDTH+18:0]         out_quo_m,
   output logic [TAG_W-1:0]               out_tag
);

   localparam int NW = COEF_WIDTH + 19;
   localparam int DV = COEF_WIDTH + 1;

   logic             v_ff    [NW+1];
   logic [NW-1:0]    np_ff   [NW+1];
   logic [NW-1:0]    nm_ff   [NW+1];
   logic [DV-1:0]    remp_ff [NW+1];
   logic [DV-1:0]    remm_ff [NW+1];
   logic [DV-1:0]    den_ff  [NW+1];
   logic [TAG_W-1:0] tag_ff  [NW+1];

   always_comb begin
      v_ff[0]    = in_valid;
      np_ff[0]   = in_num_p;
      nm_ff[0]   = in_num_m;
      remp_ff[0] = '0;
      remm_ff[0] = '0;
      den_ff[0]  = in_den;
      tag_ff[0]  = in_tag;
   end

   // The numerator register shifts left and takes the quotient bits in,
   // so after the last stage it holds the quotient.
   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DV:0] rsp_in;
      logic [DV:0] rsm_in;
      logic        gep_in;
      logic        gem_in;

      always_comb begin
         rsp_in = {remp_ff[i], np_ff[i][NW-1]};
         rsm_in = {remm_ff[i], nm_ff[i][NW-1]};
         gep_in = (rsp_in >= {1'b0, den_ff[i]});
         gem_in = (rsm_in >= {1'b0, den_ff[i]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            remp_ff[i+1] <= gep_in ? DV'(rsp_in - {1'b0, den_ff[i]}) : DV'(rsp_in);
            remm_ff[i+1] <= gem_in ? DV'(rsm_in - {1'b0, den_ff[i]}) : DV'(rsm_in);
            np_ff[i+1]   <= {np_ff[i][NW-2:0], gep_in};
            nm_ff[i+1]   <= {nm_ff[i][NW-2:0], gem_in};
            den_ff[i+1]  <= den_ff[i];
            tag_ff[i+1]  <= tag_ff[i];
         end
      end
   end

   assign out_valid = v_ff[NW];
   assign out_quo_p = np_ff[NW];
   assign out_quo_m = nm_ff[NW];
   assign out_tag   = tag_ff[NW];

endmodule

`default_nettype wire

[rtl/quadratic_root_solver_unit.sv]
// Quadratic root solver: real roots of a*x^2 + b*x + c in Q.16.
// The pipeline runs through an input register, products, discriminant, one stage per
// square root bit, numerators, one stage per quotient bit and an output register.
// Throughput is one transfer per cycle unless the output stalls the chain.
// Reset is synchronous, active high, and clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver_unit
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // coef_a, coef_b, coef_c from the lowest bit up, zero padded to bytes
   input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // root_plus, root_minus from the lowest bit up, zero padded to bytes
   output logic [((2*ROOT_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   // root_status
   output logic [STATUS_WIDTH-1:0]                     rsp_tuser
);

   localparam int W     = COEF_WIDTH;
   localparam int DW    = 2*W + 2;
   localparam int SW    = 2*W + 34;
   localparam int QW    = W + 17;
   localparam int NW    = W + 19;
   localparam int DV    = W + 1;
   localparam int EW    = ((NW > ROOT_WIDTH) ? NW : ROOT_WIDTH) + 1;
   localparam int OTW   = ((2*ROOT_WIDTH+7)/8)*8;
   localparam int STAG  = STATUS_WIDTH + 2*W;
   localparam int DTAG  = STATUS_WIDTH + 2;

   logic en;

   // Stage 1: coefficients
   logic                s1_v_ff;
   logic signed [W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;

   // Stage 2: products of magnitudes
   logic                s2_v_ff;
   logic [2*W-1:0]      s2_bsq_ff, s2_ac_ff;
   logic                s2_acneg_ff, s2_azero_ff;
   logic signed [W-1:0] s2_a_ff, s2_b_ff;

   // Stage 3: discriminant and status
   logic                s3_v_ff;
   logic [DW-1:0]       s3_d_ff;
   status_type          s3_status_ff;
   logic signed [W-1:0] s3_a_ff, s3_b_ff;

   logic [W-1:0]        a_mag_in, b_mag_in, c_mag_in;
   logic [DW-1:0]       four_in, bsq_in, d_in;
   logic                imag_in;
   status_type          status_in;

   logic                sq_v;
   logic [QW-1:0]       sq_root;
   logic [STAG-1:0]     sq_tag;

   // Numerator stage
   logic                s4_v_ff;
   logic [NW-1:0]       s4_np_ff, s4_nm_ff;
   logic [DV-1:0]       s4_den_ff;
   logic [DTAG-1:0]     s4_tag_ff;

   logic signed [W-1:0]  sq_a, sq_b;
   logic signed [NW-1:0] nb_in, np_in, nm_in, den_in;

   logic                dv_v;
   logic [NW-1:0]       dv_qp, dv_qm;
   logic [DTAG-1:0]     dv_tag;

   logic                    out_v_ff;
   logic [ROOT_WIDTH-1:0]   out_p_ff, out_m_ff;
   status_type              out_status_ff;
   logic [EW-1:0]           qp_ext_in, qm_ext_in;
   status_type              dv_status;

   // The chain moves unless a finished item sits in the last stage and the
   // output register still holds an item that has not been taken.
   assign en         = !(dv_v && out_v_ff && !rsp_tready);
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= sq_v;
      end
      if (en) begin
         s1_a_ff <= req_tdata[W-1:0];
         s1_b_ff <= req_tdata[2*W-1:W];
         s1_c_ff <= req_tdata[3*W-1:2*W];

         s2_bsq_ff   <= b_mag_in * b_mag_in;
         s2_ac_ff    <= a_mag_in * c_mag_in;
         s2_acneg_ff <= (s1_a_ff != '0) && (s1_c_ff != '0) && (s1_a_ff[W-1] != s1_c_ff[W-1]);
         s2_azero_ff <= (s1_a_ff == '0);
         s2_a_ff     <= s1_a_ff;
         s2_b_ff     <= s1_b_ff;

         s3_d_ff      <= d_in;
         s3_status_ff <= status_in;
         s3_a_ff      <= s2_a_ff;
         s3_b_ff      <= s2_b_ff;

         s4_np_ff  <= np_in[NW-1] ? NW'(-np_in) : NW'(np_in);
         s4_nm_ff  <= nm_in[NW-1] ? NW'(-nm_in) : NW'(nm_in);
         s4_den_ff <= den_in[NW-1] ? DV'(-den_in) : DV'(den_in);
         s4_tag_ff <= {sq_tag[STAG-1 -: STATUS_WIDTH],
                       np_in[NW-1] ^ den_in[NW-1],
                       nm_in[NW-1] ^ den_in[NW-1]};
      end
   end

   always_comb begin
      a_mag_in = s1_a_ff[W-1] ? W'(-s1_a_ff) : W'(s1_a_ff);
      b_mag_in = s1_b_ff[W-1] ? W'(-s1_b_ff) : W'(s1_b_ff);
      c_mag_in = s1_c_ff[W-1] ? W'(-s1_c_ff) : W'(s1_c_ff);
   end

   always_comb begin
      four_in = {s2_ac_ff, 2'b00};
      bsq_in  = {2'b00, s2_bsq_ff};
      imag_in = !s2_acneg_ff && (four_in > bsq_in);
      d_in    = s2_acneg_ff ? (bsq_in + four_in) : (bsq_in - four_in);
      if (s2_azero_ff) begin
         status_in = STATUS_NOT_QUAD;
      end else if (imag_in) begin
         status_in = STATUS_IMAG;
      end else begin
         status_in = STATUS_REAL;
      end
   end

   qrs_sqrt #(
      .COEF_WIDTH (COEF_WIDTH),
      .TAG_W      (STAG)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .in_rad    ({s3_d_ff, 32'd0}),
      .in_tag    ({s3_status_ff, s3_a_ff, s3_b_ff}),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   always_comb begin
      sq_b   = sq_tag[W-1:0];
      sq_a   = sq_tag[2*W-1:W];
      nb_in  = -(NW'(sq_b) <<< FRAC_BITS);
      np_in  = nb_in + NW'({2'b00, sq_root});
      nm_in  = nb_in - NW'({2'b00, sq_root});
      den_in = NW'(sq_a) <<< 1;
   end

   qrs_div #(
      .COEF_WIDTH (COEF_WIDTH),
      .TAG_W      (DTAG)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_num_p  (s4_np_ff),
      .in_num_m  (s4_nm_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (dv_v),
      .out_quo_p (dv_qp),
      .out_quo_m (dv_qm),
      .out_tag   (dv_tag)
   );

   always_comb begin
      dv_status = status_type'(dv_tag[DTAG-1 -: STATUS_WIDTH]);
      qp_ext_in = EW'(dv_qp);
      qm_ext_in = EW'(dv_qm);
      if (dv_tag[1]) begin
         qp_ext_in = -qp_ext_in;
      end
      if (dv_tag[0]) begin
         qm_ext_in = -qm_ext_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en && dv_v) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
      if (en && dv_v) begin
         out_status_ff <= dv_status;
         if (dv_status == STATUS_REAL) begin
            out_p_ff <= qp_ext_in[ROOT_WIDTH-1:0];
            out_m_ff <= qm_ext_in[ROOT_WIDTH-1:0];
         end else begin
            out_p_ff <= '0;
            out_m_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = OTW'({out_m_ff, out_p_ff});
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire
